// File: hw/rtl/blas_pkg.sv
// ---------------------------------------------------------------------------
// blas_pkg
// Shared types, codes and sizing for the bounded array list with set insert.
// ---------------------------------------------------------------------------
package blas_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 3;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_UNION  = 3'd3,
    OP_SEARCH = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_BAD_POS   = 3'd2,
    ST_FULL      = 3'd3,
    ST_PRESENT   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT
  } state_t;

  // result fields are masked to their port widths
  function automatic logic [INDEX_W-1:0] to_index(input logic [ADDR_W-1:0] a);
    logic [31:0] t;
    t = 32'(a);
    return t[INDEX_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] c);
    logic [31:0] t;
    t = 32'(c);
    return t[COUNT_W-1:0];
  endfunction

  // 1-based position to 0-based address; only used once the position is valid
  function automatic logic [ADDR_W-1:0] pos_to_addr(input logic [POS_W-1:0] p);
    logic [31:0] t;
    t = 32'(p) - 32'd1;
    return t[ADDR_W-1:0];
  endfunction

endpackage

// File: hw/rtl/blas_ram.sv
// ---------------------------------------------------------------------------
// blas_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module blas_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/bounded_array_list_set.sv
// ---------------------------------------------------------------------------
// bounded_array_list_set
// Bounded ordered list of signed 32-bit values with append, positional
// insert, set-style insert, search and clear.
// ---------------------------------------------------------------------------
// Usage:
//   Present opcode, value and position with start high; the item is taken
//   on a rising edge where busy is low. busy stays high while the item is
//   worked on. Exactly one result per item appears on status, index and
//   count for one cycle with done high; the receiver must take it then.
//   count holds the list length after the most recent item between results.
// Sequencing:
//   clear, append, unused opcodes, rejected inserts: finish from idle.
//   search / union insert: one read and one compare per entry, ending on a
//   match or when the whole list is compared without a match.
//   insert: one read and one write-back per entry moved up, then the put.
//   Each step of a walk uses the single RAM read port with its registered
//   read data: one read, then one compare or write-back.
//   A new item is taken only once the last one is finished; start is ignored while busy.
// Reset:
//   rst (synchronous) empties the list and returns to idle; stored values
//   are not cleared, entries beyond count are never used.
// ---------------------------------------------------------------------------
module bounded_array_list_set
  import blas_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [OPCODE_W-1:0]        opcode,
  input  logic signed [VALUE_W-1:0]  value,
  input  logic [POS_W-1:0]           position,
  output logic                       busy,
  output logic                       done,
  output logic [STATUS_W-1:0]        status,
  output logic [INDEX_W-1:0]         index,
  output logic [COUNT_W-1:0]         count
);

  state_t state, state_next;

  opcode_t             op_q;
  logic [VALUE_W-1:0]  value_q;
  logic [ADDR_W-1:0]   pos_m1;
  logic [CNT_W-1:0]    ptr;
  logic [CNT_W-1:0]    ptr_m1;
  logic [CNT_W-1:0]    count_q;

  logic                full;
  logic                accept;
  logic                pos_bad;
  logic                at_pos;
  logic                hit;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [VALUE_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [VALUE_W-1:0]  mem_rdata;

  logic                fin;
  status_t             fin_status;
  logic [ADDR_W-1:0]   fin_index;
  logic                cnt_clr;
  logic                cnt_inc;
  logic                ptr_zero;
  logic                ptr_load;
  logic                ptr_inc;
  logic                ptr_dec;

  assign accept  = start && !busy;
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign ptr_m1  = ptr - CNT_W'(1);
  assign hit     = (mem_rdata == value_q);
  assign pos_bad = (position == '0) || (32'(position) > 32'(count_q) + 32'd1);
  assign at_pos  = (32'(count_q) == 32'(position) - 32'd1);

  blas_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(VALUE_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (opcode_t'(opcode))
            OP_INSERT: begin
              if (pos_bad || full) begin
                state_next = S_IDLE;
              end else if (at_pos) begin
                state_next = S_PUT;
              end else begin
                state_next = S_SHIFT_RD;
              end
            end
            OP_UNION, OP_SEARCH: state_next = S_SCAN_RD;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN_RD:  state_next = (ptr == count_q) ? S_IDLE : S_SCAN_CMP;
      S_SCAN_CMP: state_next = hit ? S_IDLE : S_SCAN_RD;
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: state_next = (ptr_m1 == CNT_W'(pos_m1)) ? S_PUT : S_SHIFT_RD;
      S_PUT:      state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = count_q[ADDR_W-1:0];
    mem_wdata  = value_q;
    mem_raddr  = ptr[ADDR_W-1:0];
    fin        = 1'b0;
    fin_status = ST_DONE;
    fin_index  = '0;
    cnt_clr    = 1'b0;
    cnt_inc    = 1'b0;
    ptr_zero   = 1'b0;
    ptr_load   = 1'b0;
    ptr_inc    = 1'b0;
    ptr_dec    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (opcode_t'(opcode))
            OP_CLEAR: begin
              fin     = 1'b1;
              cnt_clr = 1'b1;
            end
            OP_APPEND: begin
              fin = 1'b1;
              if (full) begin
                fin_status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = value;
                fin_index = count_q[ADDR_W-1:0];
                cnt_inc   = 1'b1;
              end
            end
            OP_INSERT: begin
              if (pos_bad) begin
                fin        = 1'b1;
                fin_status = ST_BAD_POS;
              end else if (full) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
              end else begin
                ptr_load = 1'b1;
              end
            end
            OP_UNION, OP_SEARCH: ptr_zero = 1'b1;
            default: fin = 1'b1;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (ptr == count_q) begin
          // reached the end without a match
          fin = 1'b1;
          if (op_q == OP_SEARCH) begin
            fin_status = ST_NOT_FOUND;
          end else if (full) begin
            fin_status = ST_FULL;
          end else begin
            mem_we    = 1'b1;
            fin_index = count_q[ADDR_W-1:0];
            cnt_inc   = 1'b1;
          end
        end
      end
      S_SCAN_CMP: begin
        if (hit) begin
          fin        = 1'b1;
          fin_index  = ptr[ADDR_W-1:0];
          fin_status = (op_q == OP_UNION) ? ST_PRESENT : ST_DONE;
        end else begin
          ptr_inc = 1'b1;
        end
      end
      S_SHIFT_RD: begin
        mem_raddr = ptr_m1[ADDR_W-1:0];
      end
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr[ADDR_W-1:0];
        mem_wdata = mem_rdata;
        ptr_dec   = 1'b1;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_m1;
        fin       = 1'b1;
        fin_index = pos_m1;
        cnt_inc   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      busy    <= 1'b0;
      done    <= 1'b0;
      count_q <= '0;
      count   <= '0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= fin;
      if (cnt_clr) begin
        count_q <= '0;
      end else if (cnt_inc) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (fin) begin
        count <= cnt_clr ? '0 : to_count(cnt_inc ? count_q + CNT_W'(1) : count_q);
      end
    end
  end

  // item capture, walk pointer and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= opcode_t'(opcode);
      value_q <= value;
      pos_m1  <= pos_to_addr(position);
    end
    if (ptr_zero) begin
      ptr <= '0;
    end else if (ptr_load) begin
      ptr <= count_q;
    end else if (ptr_inc) begin
      ptr <= ptr + CNT_W'(1);
    end else if (ptr_dec) begin
      ptr <= ptr_m1;
    end
    if (fin) begin
      status <= fin_status;
      index  <= to_index(fin_index);
    end
  end

endmodule

// File: hw/rtl/blas_checker.sv
// ---------------------------------------------------------------------------
// blas_checker
// Port-level checks on the list block, bound into the list module.
// ---------------------------------------------------------------------------
module blas_checker
  import blas_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic [OPCODE_W-1:0]       opcode,
  input logic                      busy,
  input logic                      done,
  input logic [STATUS_W-1:0]       status,
  input logic [COUNT_W-1:0]        count
);

  // a result always ends the item, so the block is free in that cycle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_CLEAR) |=>
      (done && count == '0 && status == ST_DONE))
    else $error("clear did not empty the list");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_APPEND && 32'(count) < 32'(CAPACITY)) |=>
      (done && status == ST_DONE && count == $past(count) + COUNT_W'(1)))
    else $error("append with room did not add an item");

  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (count == COUNT_W'(CAPACITY)))
    else $error("full reported below capacity");

endmodule

bind bounded_array_list_set blas_checker u_blas_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .opcode  (opcode),
  .busy    (busy),
  .done    (done),
  .status  (status),
  .count   (count)
);
